[rtl/core/sobel_edge_threshold_core_defines.svh]
// Assertion macros shared by the Sobel edge threshold core.
`ifndef SOBEL_EDGE_THRESHOLD_CORE_DEFINES_SVH
`define SOBEL_EDGE_THRESHOLD_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SEDT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SEDT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/sedt_pkg.sv]
// Shared constants, types and helpers of the Sobel edge threshold core.
package sedt_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_PIXEL_BITS = 8;
  localparam int Q_DEPTH        = 8;

  localparam int ROW_W      = 12;
  localparam int OCOL_W     = 10;
  localparam int NUM_SLOTS  = 4;
  localparam int HEIGHT_MAX = 4096;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 21;
  localparam int CFG_W_BITS = 11;
  localparam int CFG_H_BITS = 13;
  localparam int CFG_T_BITS = 21;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_THRESHOLD = 2'd2;

  localparam logic [CFG_W_BITS-1:0] RST_IMAGE_WIDTH    = 11'd640;
  localparam logic [CFG_H_BITS-1:0] RST_IMAGE_HEIGHT   = 13'd480;
  localparam logic [CFG_T_BITS-1:0] RST_EDGE_THRESHOLD = 21'd10000;

  // Result slots of one job: the job's position and its up-left, up and left neighbors.
  localparam logic [1:0] SLOT_UP_LEFT = 2'd0;
  localparam logic [1:0] SLOT_UP      = 2'd1;
  localparam logic [1:0] SLOT_LEFT    = 2'd2;
  localparam logic [1:0] SLOT_HERE    = 2'd3;

  typedef struct packed {
    logic empty;
    logic full;
  } sedt_q_stat_t;

  // A job word is {row, col, slot enables, edge flag}.
  function automatic int job_width(int max_w);
    return ROW_W + $clog2(max_w) + NUM_SLOTS + 1;
  endfunction

endpackage

[rtl/core/sedt_queue.sv]
// Job queue between the front and back parts of the Sobel edge core.
module sedt_queue
  import sedt_pkg::*;
#(
  parameter int DATA_W = 32,
  parameter int DEPTH  = Q_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] head,
  output sedt_q_stat_t      stat
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] entries_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  assign head       = entries_r[rd_ptr_r];
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CNT_W'(DEPTH));

endmodule

[rtl/core/sedt_front.sv]
// Front part: pixel intake, position tracking, line buffer, window and gradient test.
module sedt_front
  import sedt_pkg::*;
#(
  parameter int MAX_WIDTH   = DEF_MAX_WIDTH,
  parameter int PIXEL_BITS  = DEF_PIXEL_BITS,
  parameter int QUEUE_DEPTH = Q_DEPTH,
  localparam int CW         = $clog2(MAX_WIDTH),
  localparam int JOB_W      = job_width(MAX_WIDTH)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PIXEL_BITS-1:0] in_pixel,
  input  logic                  in_frame_start,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  push,
  output logic [JOB_W-1:0]      push_data,
  input  logic                  pop
);

  localparam int PB   = PIXEL_BITS;
  localparam int GW   = PB + 3;
  localparam int AW   = PB + 2;
  localparam int SW   = 2 * AW;
  localparam int MW   = SW + 1;
  localparam int CMPW = (MW > CFG_T_BITS) ? MW : CFG_T_BITS;
  localparam int CRW  = $clog2(QUEUE_DEPTH + 1);

  logic [CFG_W_BITS-1:0] cfg_w_r;
  logic [CFG_H_BITS-1:0] cfg_h_r;
  logic [CFG_T_BITS-1:0] thr_r;

  logic [CW-1:0]    w_m1;
  logic [ROW_W-1:0] h_m1;

  logic             accept;
  logic [CRW-1:0]   credit_r;
  logic [ROW_W-1:0] row_r;
  logic [CW-1:0]    col_r;
  logic [ROW_W-1:0] r_raw;
  logic [ROW_W-1:0] r_a;
  logic [CW-1:0]    c_raw;
  logic [CW-1:0]    c_a;
  logic             eol;
  logic             last_row;
  logic [NUM_SLOTS-1:0] en_a;

  logic [2*PB-1:0]  line_mem [MAX_WIDTH];
  logic [2*PB-1:0]  rd_q_r;
  logic             byp_r;
  logic [2*PB-1:0]  byp_d_r;
  logic [2*PB-1:0]  s1_ent;
  logic [2*PB-1:0]  wr_d;

  logic                 s1_valid_r;
  logic [PB-1:0]        s1_pix_r;
  logic [ROW_W-1:0]     s1_row_r;
  logic [CW-1:0]        s1_col_r;
  logic [NUM_SLOTS-1:0] s1_en_r;
  logic                 s1_eok_r;

  logic                 s2_valid_r;
  logic [ROW_W-1:0]     s2_row_r;
  logic [CW-1:0]        s2_col_r;
  logic [NUM_SLOTS-1:0] s2_en_r;
  logic                 s2_eok_r;
  logic [PB-1:0]        win_r [9];

  logic                 s3_valid_r;
  logic [ROW_W-1:0]     s3_row_r;
  logic [CW-1:0]        s3_col_r;
  logic [NUM_SLOTS-1:0] s3_en_r;
  logic                 s3_eok_r;
  logic [AW-1:0]        ax_r;
  logic [AW-1:0]        ay_r;

  logic                 s4_valid_r;
  logic [ROW_W-1:0]     s4_row_r;
  logic [CW-1:0]        s4_col_r;
  logic [NUM_SLOTS-1:0] s4_en_r;
  logic                 s4_eok_r;
  logic [SW-1:0]        sqx_r;
  logic [SW-1:0]        sqy_r;

  logic signed [GW-1:0] pw [9];
  logic signed [GW-1:0] gx;
  logic signed [GW-1:0] gy;
  logic signed [GW-1:0] gx_abs;
  logic signed [GW-1:0] gy_abs;
  logic [SW-1:0]        sqx;
  logic [SW-1:0]        sqy;
  logic [MW-1:0]        mag;
  logic                 edge_bit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_w_r <= RST_IMAGE_WIDTH;
      cfg_h_r <= RST_IMAGE_HEIGHT;
      thr_r   <= RST_EDGE_THRESHOLD;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:    cfg_w_r <= cfg_wdata[CFG_W_BITS-1:0];
        CFG_IMAGE_HEIGHT:   cfg_h_r <= cfg_wdata[CFG_H_BITS-1:0];
        CFG_EDGE_THRESHOLD: thr_r   <= cfg_wdata[CFG_T_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Frame size clamped to the supported range, minus one.
  always_comb begin
    if (cfg_w_r < CFG_W_BITS'(3)) begin
      w_m1 = CW'(2);
    end else if (32'(cfg_w_r) > MAX_WIDTH) begin
      w_m1 = CW'(MAX_WIDTH - 1);
    end else begin
      w_m1 = CW'(cfg_w_r - CFG_W_BITS'(1));
    end
    if (cfg_h_r < CFG_H_BITS'(3)) begin
      h_m1 = ROW_W'(2);
    end else if (32'(cfg_h_r) > HEIGHT_MAX) begin
      h_m1 = ROW_W'(HEIGHT_MAX - 1);
    end else begin
      h_m1 = ROW_W'(cfg_h_r - CFG_H_BITS'(1));
    end
  end

  // Every accepted word holds a credit until its job leaves the queue.
  assign in_stall = (credit_r >= CRW'(QUEUE_DEPTH));
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= '0;
    end else begin
      case ({accept, pop})
        2'b10:   credit_r <= credit_r + CRW'(1);
        2'b01:   credit_r <= credit_r - CRW'(1);
        default: credit_r <= credit_r;
      endcase
    end
  end

  always_comb begin
    r_raw    = in_frame_start ? '0 : row_r;
    c_raw    = in_frame_start ? '0 : col_r;
    r_a      = (r_raw > h_m1) ? h_m1 : r_raw;
    c_a      = (c_raw > w_m1) ? w_m1 : c_raw;
    eol      = (c_a == w_m1);
    last_row = (r_a == h_m1);
    en_a[SLOT_UP_LEFT] = (r_a != '0) && (c_a != '0);
    en_a[SLOT_UP]      = (r_a != '0) && eol;
    en_a[SLOT_LEFT]    = last_row && (c_a != '0);
    en_a[SLOT_HERE]    = last_row && eol;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else if (accept) begin
      if (eol) begin
        col_r <= '0;
        row_r <= last_row ? '0 : r_a + ROW_W'(1);
      end else begin
        col_r <= c_a + CW'(1);
        row_r <= r_a;
      end
    end
  end

  // Each line buffer entry holds {two rows up, one row up} for its column.
  assign s1_ent = byp_r ? byp_d_r : rd_q_r;
  assign wr_d   = {s1_ent[PB-1:0], s1_pix_r};

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_q_r <= line_mem[c_a];
    end
    if (s1_valid_r) begin
      line_mem[s1_col_r] <= wr_d;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      byp_r    <= s1_valid_r && (s1_col_r == c_a);
      byp_d_r  <= wr_d;
      s1_pix_r <= in_pixel;
      s1_row_r <= r_a;
      s1_col_r <= c_a;
      s1_en_r  <= en_a;
      s1_eok_r <= (r_a >= ROW_W'(2)) && (c_a >= CW'(2));
    end
    s2_row_r <= s1_row_r;
    s2_col_r <= s1_col_r;
    s2_en_r  <= s1_en_r;
    s2_eok_r <= s1_eok_r;
    s3_row_r <= s2_row_r;
    s3_col_r <= s2_col_r;
    s3_en_r  <= s2_en_r;
    s3_eok_r <= s2_eok_r;
    ax_r     <= gx_abs[AW-1:0];
    ay_r     <= gy_abs[AW-1:0];
    s4_row_r <= s3_row_r;
    s4_col_r <= s3_col_r;
    s4_en_r  <= s3_en_r;
    s4_eok_r <= s3_eok_r;
    sqx_r    <= sqx;
    sqy_r    <= sqy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      s4_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= accept;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_valid_r) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k*3]     <= win_r[k*3 + 1];
        win_r[k*3 + 1] <= win_r[k*3 + 2];
      end
      win_r[2] <= s1_ent[2*PB-1:PB];
      win_r[5] <= s1_ent[PB-1:0];
      win_r[8] <= s1_pix_r;
    end
  end

  always_comb begin
    for (int i = 0; i < 9; i++) begin
      pw[i] = $signed({3'b000, win_r[i]});
    end
    gx     = pw[2] + (pw[5] <<< 1) + pw[8] - pw[0] - (pw[3] <<< 1) - pw[6];
    gy     = pw[0] + (pw[1] <<< 1) + pw[2] - pw[6] - (pw[7] <<< 1) - pw[8];
    gx_abs = gx[GW-1] ? -gx : gx;
    gy_abs = gy[GW-1] ? -gy : gy;
  end

  assign sqx      = ax_r * ax_r;
  assign sqy      = ay_r * ay_r;
  assign mag      = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign edge_bit = s4_eok_r && (CMPW'(mag) > CMPW'(thr_r));

  assign push      = s4_valid_r;
  assign push_data = {s4_row_r, s4_col_r, s4_en_r, edge_bit};

endmodule

[rtl/core/sedt_back.sv]
// Back part: expands each job into its result words and drives the output register.
module sedt_back
  import sedt_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH,
  localparam int CW       = $clog2(MAX_WIDTH),
  localparam int JOB_W    = job_width(MAX_WIDTH)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sedt_q_stat_t      q_stat,
  input  logic [JOB_W-1:0]  q_head,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_edge_res,
  output logic [ROW_W-1:0]  out_row,
  output logic [OCOL_W-1:0] out_col,
  output logic              out_frame_last
);

  logic [JOB_W-1:0]     job_r;
  logic [NUM_SLOTS-1:0] pend_r;
  logic [NUM_SLOTS-1:0] pend_after;
  logic [1:0]           pick;
  logic                 load_ok;
  logic                 emit;

  logic [ROW_W-1:0]     job_row;
  logic [CW-1:0]        job_col;
  logic                 job_edge;
  logic [ROW_W-1:0]     res_row;
  logic [CW-1:0]        res_col;

  logic                 out_valid_r;
  logic                 out_edge_r;
  logic [ROW_W-1:0]     out_row_r;
  logic [OCOL_W-1:0]    out_col_r;
  logic                 out_last_r;

  assign job_row  = job_r[JOB_W-1 -: ROW_W];
  assign job_col  = job_r[NUM_SLOTS+1 +: CW];
  assign job_edge = job_r[0];

  always_comb begin
    if (pend_r[SLOT_UP_LEFT]) begin
      pick = SLOT_UP_LEFT;
    end else if (pend_r[SLOT_UP]) begin
      pick = SLOT_UP;
    end else if (pend_r[SLOT_LEFT]) begin
      pick = SLOT_LEFT;
    end else begin
      pick = SLOT_HERE;
    end
  end

  always_comb begin
    case (pick)
      SLOT_UP_LEFT: begin
        res_row = job_row - ROW_W'(1);
        res_col = job_col - CW'(1);
      end
      SLOT_UP: begin
        res_row = job_row - ROW_W'(1);
        res_col = job_col;
      end
      SLOT_LEFT: begin
        res_row = job_row;
        res_col = job_col - CW'(1);
      end
      default: begin
        res_row = job_row;
        res_col = job_col;
      end
    endcase
  end

  assign load_ok    = !out_valid_r || !out_stall;
  assign emit       = load_ok && (pend_r != '0);
  assign pend_after = emit ? (pend_r & ~(NUM_SLOTS'(1) << pick)) : pend_r;
  assign q_pop      = !q_stat.empty && (pend_after == '0);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_head;
    end
    if (emit) begin
      out_edge_r <= (pick == SLOT_UP_LEFT) && job_edge;
      out_row_r  <= res_row;
      out_col_r  <= OCOL_W'(res_col);
      out_last_r <= (pick == SLOT_HERE);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pend_r <= q_pop ? q_head[1 +: NUM_SLOTS] : pend_after;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_edge_res   = out_edge_r;
  assign out_row        = out_row_r;
  assign out_col        = out_col_r;
  assign out_frame_last = out_last_r;

endmodule

[rtl/core/sobel_edge_threshold_core.sv]
// Top level of the streaming 3x3 Sobel edge threshold core.
// Accepts one pixel word per cycle while in_stall is low; the front pipeline is four
// stages deep. Row ends emit two result words and the last row up to four; the back
// part drains one per cycle while out_stall is low from an eight-deep job queue,
// which then sets the rate.
// Synchronous active-low reset clears control and position; line buffer is not cleared.
`include "sobel_edge_threshold_core_defines.svh"
module sobel_edge_threshold_core
  import sedt_pkg::*;
#(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [PIXEL_BITS-1:0] in_pixel,
  input  logic                  in_frame_start,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_edge_res,
  output logic [ROW_W-1:0]      out_row,
  output logic [OCOL_W-1:0]     out_col,
  output logic                  out_frame_last,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int JOB_W = job_width(MAX_WIDTH);

  logic             q_push;
  logic [JOB_W-1:0] q_push_data;
  logic             q_pop;
  logic [JOB_W-1:0] q_head;
  sedt_q_stat_t     q_stat;

  sedt_front #(
    .MAX_WIDTH   (MAX_WIDTH),
    .PIXEL_BITS  (PIXEL_BITS),
    .QUEUE_DEPTH (Q_DEPTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel       (in_pixel),
    .in_frame_start (in_frame_start),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .push           (q_push),
    .push_data      (q_push_data),
    .pop            (q_pop)
  );

  sedt_queue #(
    .DATA_W (JOB_W),
    .DEPTH  (Q_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  sedt_back #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_stat         (q_stat),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_edge_res   (out_edge_res),
    .out_row        (out_row),
    .out_col        (out_col),
    .out_frame_last (out_frame_last)
  );

  `SEDT_ASSERT_IMPL(a_q_no_overflow, clk, rst_n, q_push, !q_stat.full, "job queue overflow")
  `SEDT_ASSERT_IMPL(a_q_no_underflow, clk, rst_n, q_pop, !q_stat.empty, "job queue underflow")
  `SEDT_ASSERT_IMPL(a_full_stalls, clk, rst_n, q_stat.full, in_stall, "input open on full queue")

endmodule

[sim/testbench.sv]
// Testbench for the Sobel edge threshold core: directed table and random frames.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import sedt_pkg::*;

  localparam int PIX_W = DEF_PIXEL_BITS;
  localparam int DRAIN_GAP = 24;
  localparam int LONG_HOLD = 200;
  localparam int RAND_ITEMS = 110;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;

  typedef struct packed {
    logic              edge_res;
    logic [ROW_W-1:0]  row;
    logic [OCOL_W-1:0] col;
    logic              last;
  } sobel_res_t;

  typedef enum {STEP_PIXELS, STEP_REG} step_kind_t;

  typedef struct {
    step_kind_t            kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [PIX_W-1:0]      pixel;
    logic                  fs;
    int                    reps;
    int                    typed_n;
    sobel_res_t            typed;
  } step_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [PIX_W-1:0]      in_pixel = '0;
  logic                  in_frame_start = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  out_edge_res;
  logic [ROW_W-1:0]      out_row;
  logic [OCOL_W-1:0]     out_col;
  logic                  out_frame_last;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic [CFG_W_BITS-1:0] reg_width = RST_IMAGE_WIDTH;
  logic [CFG_H_BITS-1:0] reg_height = RST_IMAGE_HEIGHT;
  logic [CFG_T_BITS-1:0] reg_thresh = RST_EDGE_THRESHOLD;
  logic [PIX_W-1:0]      lb_above [DEF_MAX_WIDTH];
  logic [PIX_W-1:0]      lb_two_above [DEF_MAX_WIDTH];
  logic [PIX_W-1:0]      win [9];
  int                    pos_row = 0;
  int                    pos_col = 0;

  sobel_res_t sobel_expected [$];
  sobel_res_t step_out [$];
  step_t      plan [$];
  int         err_count = 0;
  bit         calm = 1'b0;
  int         hold_requests = 0;

  sobel_edge_threshold_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_pixel(in_pixel), .in_frame_start(in_frame_start),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_edge_res(out_edge_res), .out_row(out_row), .out_col(out_col),
    .out_frame_last(out_frame_last),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  task automatic note_mismatch(input string msg);
    $display("mismatch: %s", msg);
    err_count++;
  endtask

  function automatic int eff_w();
    int w;
    w = int'(reg_width);
    if (w < 3) w = 3;
    if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
    return w;
  endfunction

  function automatic int eff_h();
    int h;
    h = int'(reg_height);
    if (h < 3) h = 3;
    if (h > HEIGHT_MAX) h = HEIGHT_MAX;
    return h;
  endfunction

  function automatic sobel_res_t mk_res(int r, int c, logic e, int h, int w);
    sobel_res_t res;
    res.edge_res = e;
    res.row = ROW_W'(r);
    res.col = OCOL_W'(c);
    res.last = (r == h - 1 && c == w - 1);
    return res;
  endfunction

  task automatic sobel_predict(input logic [PIX_W-1:0] pix, input logic fs);
    int w, h, r, c, k, gx, gy, mag;
    logic is_edge, eol;
    w = eff_w();
    h = eff_h();
    r = fs ? 0 : pos_row;
    c = fs ? 0 : pos_col;
    if (r > h - 1) r = h - 1;
    if (c > w - 1) c = w - 1;
    for (k = 0; k < 3; k++) begin
      win[k*3] = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = lb_two_above[c];
    win[5] = lb_above[c];
    win[8] = pix;
    lb_two_above[c] = lb_above[c];
    lb_above[c] = pix;
    gx = int'(win[2]) + 2 * int'(win[5]) + int'(win[8])
       - int'(win[0]) - 2 * int'(win[3]) - int'(win[6]);
    gy = int'(win[0]) + 2 * int'(win[1]) + int'(win[2])
       - int'(win[6]) - 2 * int'(win[7]) - int'(win[8]);
    mag = gx * gx + gy * gy;
    is_edge = (r >= 2 && c >= 2) && (mag > int'(reg_thresh));
    eol = (c == w - 1);
    step_out.delete();
    if (r >= 1) begin
      if (c >= 1) step_out.push_back(mk_res(r - 1, c - 1, is_edge, h, w));
      if (eol) step_out.push_back(mk_res(r - 1, w - 1, 1'b0, h, w));
    end
    if (r == h - 1) begin
      if (c >= 1) step_out.push_back(mk_res(r, c - 1, 1'b0, h, w));
      if (eol) step_out.push_back(mk_res(r, w - 1, 1'b0, h, w));
    end
    if (eol) begin
      pos_col = 0;
      pos_row = (r == h - 1) ? 0 : r + 1;
    end else begin
      pos_col = c + 1;
      pos_row = r;
    end
  endtask

  task automatic push_pixel(input logic [PIX_W-1:0] pix, input logic fs,
                            input int typed_n, input sobel_res_t typed);
    int gap;
    in_valid <= 1'b1;
    in_pixel <= pix;
    in_frame_start <= fs;
    do @(posedge clk); while (in_stall);
    sobel_predict(pix, fs);
    if (typed_n < 0) begin
      foreach (step_out[k]) sobel_expected.push_back(step_out[k]);
    end else if (typed_n > 0) begin
      sobel_expected.push_back(typed);
    end
    if (!calm && $urandom_range(0, 99) < 15) begin
      gap = $urandom_range(1, 2);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    int guard;
    in_valid <= 1'b0;
    guard = 0;
    while (sobel_expected.size() != 0 && guard < 50000) begin
      @(posedge clk);
      guard++;
    end
    if (sobel_expected.size() != 0) begin
      note_mismatch($sformatf("%0d result words never arrived", sobel_expected.size()));
      sobel_expected.delete();
    end
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_IMAGE_WIDTH:    reg_width = data[CFG_W_BITS-1:0];
      CFG_IMAGE_HEIGHT:   reg_height = data[CFG_H_BITS-1:0];
      CFG_EDGE_THRESHOLD: reg_thresh = data[CFG_T_BITS-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic step_t px(logic [PIX_W-1:0] pix, logic fs, int reps,
                               int typed_n, sobel_res_t typed);
    step_t s;
    s.kind = STEP_PIXELS;
    s.idx = '0;
    s.data = '0;
    s.pixel = pix;
    s.fs = fs;
    s.reps = reps;
    s.typed_n = typed_n;
    s.typed = typed;
    return s;
  endfunction

  function automatic step_t rg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    step_t s;
    s.kind = STEP_REG;
    s.idx = idx;
    s.data = data;
    s.pixel = '0;
    s.fs = 1'b0;
    s.reps = 0;
    s.typed_n = -1;
    s.typed = '0;
    return s;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_width();
    case ($urandom_range(0, 7))
      0: return CFG_DATA_W'($urandom_range(0, 2));
      default: return CFG_DATA_W'($urandom_range(3, 8));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_height();
    case ($urandom_range(0, 9))
      0: return CFG_DATA_W'($urandom_range(0, 2));
      1: return CFG_DATA_W'(HEIGHT_MAX);
      2: return 21'd8191;
      default: return CFG_DATA_W'($urandom_range(3, 6));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_thresh();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 21'h1FFFFF;
      2: return CFG_DATA_W'($urandom_range(0, 2097151));
      default: return CFG_DATA_W'($urandom_range(0, 400000));
    endcase
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return PIX_W'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    int hold_left, hold_served;
    sobel_res_t got, want;
    hold_left = 0;
    hold_served = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got = '{out_edge_res, out_row, out_col, out_frame_last};
        if (sobel_expected.size() == 0) begin
          note_mismatch($sformatf("unexpected word row %0d col %0d", got.row, got.col));
        end else begin
          want = sobel_expected.pop_front();
          if (got.edge_res !== want.edge_res || got.row !== want.row ||
              got.col !== want.col || got.last !== want.last)
            note_mismatch($sformatf("got e%0b r%0d c%0d l%0b, want e%0b r%0d c%0d l%0b",
                                    got.edge_res, got.row, got.col, got.last,
                                    want.edge_res, want.row, want.col, want.last));
        end
      end
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(0, 99) < 15);
      end
    end
  end

  initial begin
    int i, j, n, w, h, old_w, phase, rand_items;
    logic fs, force_fs;
    foreach (lb_above[k]) begin
      lb_above[k] = '0;
      lb_two_above[k] = '0;
    end
    foreach (win[k]) win[k] = '0;

    // A frame at the reset threshold, entered mid-row after the width shrinks.
    plan.push_back(rg(CFG_IMAGE_WIDTH, 21'd8));
    plan.push_back(rg(CFG_IMAGE_HEIGHT, 21'd3));
    plan.push_back(px(8'd0, 1'b1, 1, 0, '0));
    plan.push_back(px(8'd0, 1'b0, 7, 0, '0));
    plan.push_back(px(8'd0, 1'b0, 1, 0, '0));
    plan.push_back(px(8'd0, 1'b0, 1, 1, '{1'b0, 12'd0, 10'd0, 1'b0}));
    plan.push_back(px(8'd255, 1'b0, 1, 1, '{1'b0, 12'd0, 10'd1, 1'b0}));
    plan.push_back(rg(CFG_IMAGE_WIDTH, 21'd3));
    plan.push_back(px(8'd255, 1'b0, 1, -1, '0));
    plan.push_back(px(8'd0, 1'b0, 3, -1, '0));
    plan.push_back(rg(CFG_EDGE_THRESHOLD, 21'd0));
    // A bright top row over a dark frame, around the strict threshold bound.
    plan.push_back(px(8'd255, 1'b1, 3, -1, '0));
    plan.push_back(px(8'd0, 1'b0, 6, -1, '0));
    plan.push_back(rg(CFG_EDGE_THRESHOLD, 21'd1040400));
    plan.push_back(px(8'd255, 1'b1, 3, -1, '0));
    plan.push_back(px(8'd0, 1'b0, 6, -1, '0));
    plan.push_back(rg(CFG_EDGE_THRESHOLD, 21'd1040399));
    plan.push_back(px(8'd255, 1'b1, 3, -1, '0));
    plan.push_back(px(8'd0, 1'b0, 6, -1, '0));
    // A frame start in mid-frame, then a row that saturates after the height shrinks.
    plan.push_back(px(8'd100, 1'b1, 5, -1, '0));
    plan.push_back(px(8'd50, 1'b1, 9, -1, '0));
    plan.push_back(rg(CFG_IMAGE_WIDTH, 21'd0));
    plan.push_back(rg(CFG_IMAGE_HEIGHT, 21'd6));
    plan.push_back(px(8'd30, 1'b1, 13, -1, '0));
    plan.push_back(rg(CFG_IMAGE_HEIGHT, 21'd0));
    plan.push_back(px(8'd200, 1'b0, 2, -1, '0));
    plan.push_back(rg(CFG_SPARE_INDEX, 21'h1FFFFF));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan[k]) begin
      if (plan[k].kind == STEP_REG) begin
        settle();
        reg_write(plan[k].idx, plan[k].data);
      end else begin
        for (j = 0; j < plan[k].reps; j++)
          push_pixel(plan[k].pixel, plan[k].fs && (j == 0), plan[k].typed_n, plan[k].typed);
      end
    end

    phase = 0;
    rand_items = 0;
    while (rand_items < RAND_ITEMS) begin
      settle();
      old_w = eff_w();
      if (phase == 0 || $urandom_range(0, 1)) reg_write(CFG_IMAGE_WIDTH, pick_width());
      if (phase == 0 || $urandom_range(0, 1)) reg_write(CFG_IMAGE_HEIGHT, pick_height());
      if (phase == 0 || $urandom_range(0, 1)) reg_write(CFG_EDGE_THRESHOLD, pick_thresh());
      w = eff_w();
      h = eff_h();
      // A wider row would read line-buffer entries never written in this frame.
      force_fs = (w > old_w) && (pos_row != 0 || pos_col != 0);
      if (h > 8) n = w * $urandom_range(2, 4) + $urandom_range(0, w - 1);
      else n = w * h * $urandom_range(1, 2) + $urandom_range(0, w - 1);
      if (phase == 1) begin
        n += 40;
        hold_requests++;
      end
      calm = (phase == 0);
      for (i = 0; i < n; i++) begin
        if (i == 0) fs = force_fs || ($urandom_range(0, 3) != 0);
        else fs = ($urandom_range(0, 59) == 0);
        push_pixel(pick_pixel(), fs, -1, '0);
      end
      calm = 1'b0;
      rand_items += n;
      phase++;
    end

    settle();
    if (err_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
